>>> src/pid_controller_step_assert.svh
// ----------------------------------------------------------------------------
// PID controller step assertion macros
// Shared property macros for the concurrent checks of the controller.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_STEP_ASSERT_SVH
`define PID_CONTROLLER_STEP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCS_ASSERT_IMPL(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCS_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

>>> src/pcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller step package
// Shared constants, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // Elapsed time is 16 bits in units of 1/65536 second.
  localparam int DT_W     = 16;
  localparam int DT_SHIFT = 16;

  // Multiplier consumes the second operand in chunks of this many bits.
  localparam int CHUNK_W = 16;

  // Gain terms are clamped to +-(2^61 - 1) and summed in 64 bits.
  localparam int TERM_BITS = 61;
  localparam int SUM_W     = 64;

  localparam int CFG_IDX_W = 3;
  localparam int MODE_W    = 2;
  localparam int MODE_WRAP  = 0;
  localparam int MODE_CLEAR = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE  = 3'd0,
    CFG_SPAN  = 3'd1,
    CFG_ZONE  = 3'd2,
    CFG_MIN   = 3'd3,
    CFG_MAX   = 3'd4,
    CFG_KP    = 3'd5,
    CFG_KI    = 3'd6,
    CFG_KD    = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MUL_INTEG = 2'd0,
    MUL_P     = 2'd1,
    MUL_I     = 2'd2,
    MUL_D     = 2'd3
  } mul_sel_e;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic     load;
    logic     div_start;
    logic     div_deriv;
    logic     wrap_en;
    logic     deriv_en;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     mul_capture;
    logic     out_en;
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic wrap_needed;
    logic deriv_needed;
  } status_t;

endpackage

>>> src/pcs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller serial divider
// Unsigned restoring divider, one quotient bit per cycle, optional short run.
// ----------------------------------------------------------------------------
module pcs_div #(
  parameter int DDW     = 50,
  parameter int DSW     = 31,
  parameter int SHORT_N = 33
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           short_i,
  input  logic [DDW-1:0] dividend_i,
  input  logic [DSW-1:0] divisor_i,
  output logic           done_o,
  output logic [DDW-1:0] quot_o,
  output logic [DSW-1:0] rem_o
);

  localparam int CW = $clog2(DDW + 1);

  logic           busy_q;
  logic           done_q;
  logic [CW-1:0]  cnt_q;
  logic [DDW-1:0] quot_q;
  logic [DSW-1:0] rem_q;
  logic [DSW-1:0] dvs_q;
  logic [DSW:0]   shifted;
  logic           fits;

  // Bring down the next dividend bit and try a subtraction.
  assign shifted = {rem_q, quot_q[DDW-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  // Sequencing of the iterations.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= short_i ? CW'(SHORT_N) : CW'(DDW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= short_i ? (dividend_i << (DDW - SHORT_N)) : dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[DDW-2:0], fits};
      rem_q  <= fits ? DSW'(shifted - {1'b0, dvs_q}) : shifted[DSW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

>>> src/pcs_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller chunked multiplier
// Signed multiply that takes the second operand a chunk per cycle, top first.
// ----------------------------------------------------------------------------
module pcs_mul
  import pcs_pkg::*;
#(
  parameter int AW = 33,
  parameter int BW = 51
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic                 done_o,
  output logic signed [AW+((BW+CHUNK_W-1)/CHUNK_W)*CHUNK_W-1:0] prod_o
);

  localparam int NCH = (BW + CHUNK_W - 1) / CHUNK_W;
  localparam int XW  = NCH * CHUNK_W;
  localparam int PW  = AW + XW;
  localparam int PPW = AW + CHUNK_W + 1;
  localparam int CNW = $clog2(NCH + 1);

  logic                  busy_q;
  logic                  done_q;
  logic                  pv_q;
  logic [CNW-1:0]        cnt_q;
  logic signed [AW-1:0]  a_q;
  logic [XW-1:0]         b_q;
  logic signed [PPW-1:0] pp_q;
  logic signed [PW-1:0]  acc_q;
  logic signed [CHUNK_W:0] chunk;

  // The top chunk carries the sign, the others are unsigned.
  assign chunk = $signed({(cnt_q == '0) ? b_q[XW-1] : 1'b0, b_q[XW-1 -: CHUNK_W]});

  // Control of the chunk sequence.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      pv_q   <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        pv_q   <= 1'b0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q != CNW'(NCH)) begin
          cnt_q <= cnt_q + CNW'(1);
          pv_q  <= 1'b1;
        end else begin
          pv_q <= 1'b0;
          if (pv_q) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  // Partial product register, then shift-and-add accumulation.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= XW'(b_i);
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q != CNW'(NCH)) begin
        pp_q <= PPW'(a_q * chunk);
        b_q  <= b_q << CHUNK_W;
      end
      if (pv_q) begin
        acc_q <= (acc_q <<< CHUNK_W) + PW'(pp_q);
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

>>> src/pcs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller datapath
// Error, wrap, integral, derivative and gain terms with shared arithmetic units.
// ----------------------------------------------------------------------------
module pcs_datapath
  import pcs_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cmd_t                          cmd_i,
  output status_t                       status_o,
  input  logic signed [VALUE_WIDTH-1:0] target_i,
  input  logic signed [VALUE_WIDTH-1:0] measured_i,
  input  logic [DT_W-1:0]               step_time_i,
  input  logic [MODE_W-1:0]             mode_i,
  input  logic [VALUE_WIDTH-2:0]        span_i,
  input  logic [VALUE_WIDTH-2:0]        zone_i,
  input  logic signed [VALUE_WIDTH-1:0] out_min_i,
  input  logic signed [VALUE_WIDTH-1:0] out_max_i,
  input  logic signed [VALUE_WIDTH-1:0] kp_i,
  input  logic signed [VALUE_WIDTH-1:0] ki_i,
  input  logic signed [VALUE_WIDTH-1:0] kd_i,
  output logic signed [VALUE_WIDTH-1:0] drive_o
);

  localparam int EW   = VALUE_WIDTH + 1;
  localparam int IW   = VALUE_WIDTH + 8;
  localparam int DIW  = VALUE_WIDTH + 2;
  localparam int DDW  = DIW + DT_SHIFT;
  localparam int BW   = DDW + 1;
  localparam int DSW  = (VALUE_WIDTH - 1 > DT_W) ? VALUE_WIDTH - 1 : DT_W;
  localparam int NCH  = (BW + CHUNK_W - 1) / CHUNK_W;
  localparam int PW   = EW + NCH * CHUNK_W;

  localparam logic signed [PW-1:0] TLIM =
    $signed({{(PW - TERM_BITS){1'b0}}, {TERM_BITS{1'b1}}});

  logic signed [EW-1:0]    err_q;
  logic [DT_W-1:0]         dt_q;
  logic signed [IW-1:0]    integ_q;
  logic signed [EW-1:0]    prev_q;
  logic                    prev_valid_q;
  logic signed [BW-1:0]    deriv_q;
  logic signed [SUM_W-1:0] p_q, i_q, d_q;
  logic signed [VALUE_WIDTH-1:0] drive_q;

  logic [EW-1:0]           err_mag;
  logic signed [DIW-1:0]   diff;
  logic [DIW-1:0]          diff_mag;
  logic [DDW-1:0]          div_dividend;
  logic [DSW-1:0]          div_divisor;
  logic                    div_done;
  logic [DDW-1:0]          div_quot;
  logic [DSW-1:0]          div_rem;

  logic signed [EW-1:0]    mul_a;
  logic signed [BW-1:0]    mul_b;
  logic                    mul_done;
  logic signed [PW-1:0]    mul_prod;

  logic signed [EW-1:0]    wrap_val;
  logic signed [EW-1:0]    rem_s;
  logic signed [IW:0]      inc;
  logic signed [IW:0]      isum_new;
  logic signed [IW-1:0]    isum_src;
  logic signed [IW-1:0]    integ_val;
  logic                    sign_clear;
  logic                    in_zone;
  logic signed [SUM_W-1:0] term_val;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] lim_hi;
  logic signed [SUM_W-1:0] lim_lo;

  // Floor shift of a product by the fraction bits, clamped to the term limit.
  function automatic logic signed [SUM_W-1:0] term_clamp(input logic signed [PW-1:0] prod);
    logic signed [PW-1:0] sh;
    sh = prod >>> FRAC_BITS;
    if (sh > TLIM) begin
      sh = TLIM;
    end else if (sh < -TLIM) begin
      sh = -TLIM;
    end
    return SUM_W'(sh);
  endfunction

  // Magnitudes that feed the divider.
  assign err_mag  = err_q[EW-1] ? EW'(-err_q) : err_q;
  assign diff     = DIW'(err_q) - DIW'(prev_q);
  assign diff_mag = diff[DIW-1] ? DIW'(-diff) : diff;

  assign div_dividend = cmd_i.div_deriv ? {diff_mag, {DT_SHIFT{1'b0}}} : DDW'(err_mag);
  assign div_divisor  = cmd_i.div_deriv ? DSW'(dt_q) : DSW'(span_i);

  pcs_div #(
    .DDW     (DDW),
    .DSW     (DSW),
    .SHORT_N (EW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .short_i    (!cmd_i.div_deriv),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_INTEG: begin
        mul_a = err_q;
        mul_b = BW'($signed({1'b0, dt_q}));
      end
      MUL_P: begin
        mul_a = EW'(kp_i);
        mul_b = BW'(err_q);
      end
      MUL_I: begin
        mul_a = EW'(ki_i);
        mul_b = BW'(integ_q);
      end
      default: begin
        mul_a = EW'(kd_i);
        mul_b = deriv_q;
      end
    endcase
  end

  pcs_mul #(
    .AW (EW),
    .BW (BW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // Continuous-input wrap: signed truncating remainder folded into half a span.
  always_comb begin
    rem_s    = err_q[EW-1] ? EW'(-$signed({1'b0, div_rem})) : EW'($signed({1'b0, div_rem}));
    wrap_val = rem_s;
    if ({div_rem, 1'b0} > (DSW + 1)'(span_i)) begin
      if (err_q[EW-1]) begin
        wrap_val = rem_s + EW'($signed({1'b0, span_i}));
      end else begin
        wrap_val = rem_s - EW'($signed({1'b0, span_i}));
      end
    end
  end

  // Integral update: sign-change clear, zone test, saturating accumulate.
  always_comb begin
    sign_clear = mode_i[MODE_CLEAR] && (err_q != '0) && (integ_q != '0) &&
                 (err_q[EW-1] != integ_q[IW-1]);
    in_zone    = {1'b0, err_mag, 1'b0} < (EW + 1)'(zone_i);
    isum_src   = sign_clear ? '0 : integ_q;
    inc        = (IW + 1)'(mul_prod >>> DT_SHIFT);
    isum_new   = (IW + 1)'(isum_src) + inc;
    if (isum_new[IW] != isum_new[IW-1]) begin
      integ_val = isum_new[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    end else begin
      integ_val = isum_new[IW-1:0];
    end
    if (!in_zone) begin
      integ_val = '0;
    end
  end

  assign term_val = term_clamp(mul_prod);

  // Output sum and limits; crossed limits end on the lower one.
  always_comb begin
    lim_hi = SUM_W'(out_max_i);
    lim_lo = SUM_W'(out_min_i);
    sum    = p_q + i_q + d_q;
    if (sum > lim_hi) begin
      sum = lim_hi;
    end
    if (sum < lim_lo) begin
      sum = lim_lo;
    end
  end

  // Controller state carried from item to item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q      <= '0;
      prev_q       <= '0;
      prev_valid_q <= 1'b0;
    end else begin
      if (cmd_i.mul_capture && (cmd_i.mul_sel == MUL_INTEG)) begin
        integ_q <= integ_val;
      end
      if (cmd_i.out_en) begin
        prev_q       <= err_q;
        prev_valid_q <= 1'b1;
      end
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      err_q   <= EW'(target_i) - EW'(measured_i);
      dt_q    <= step_time_i;
      deriv_q <= '0;
    end
    if (cmd_i.wrap_en) begin
      err_q <= wrap_val;
    end
    if (cmd_i.deriv_en) begin
      deriv_q <= diff[DIW-1] ? -BW'(div_quot) : BW'(div_quot);
    end
    if (cmd_i.mul_capture) begin
      case (cmd_i.mul_sel)
        MUL_P:   p_q <= term_val;
        MUL_I:   i_q <= term_val;
        MUL_D:   d_q <= term_val;
        default: ;
      endcase
    end
    if (cmd_i.out_en) begin
      drive_q <= sum[VALUE_WIDTH-1:0];
    end
  end

  assign status_o.div_done     = div_done;
  assign status_o.mul_done     = mul_done;
  assign status_o.wrap_needed  = mode_i[MODE_WRAP] && (span_i != '0);
  assign status_o.deriv_needed = prev_valid_q && (dt_q != '0);
  assign drive_o               = drive_q;

endmodule

>>> src/pcs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller sequencer
// State machine that steps one item through the datapath operations.
// ----------------------------------------------------------------------------
module pcs_ctrl
  import pcs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    out_free_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP,
    ST_WRAP_WAIT,
    ST_INTEG,
    ST_INTEG_WAIT,
    ST_DERIV,
    ST_DERIV_WAIT,
    ST_P,
    ST_P_WAIT,
    ST_I,
    ST_I_WAIT,
    ST_D,
    ST_D_WAIT,
    ST_FINISH
  } state_e;

  state_e state_q;
  state_e state_d;

  // Next state and commands for the current state.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_WRAP;
        end
      end
      ST_WRAP: begin
        if (status_i.wrap_needed) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_WRAP_WAIT;
        end else begin
          state_d = ST_INTEG;
        end
      end
      ST_WRAP_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.wrap_en = 1'b1;
          state_d       = ST_INTEG;
        end
      end
      ST_INTEG: begin
        cmd_o.mul_sel   = MUL_INTEG;
        cmd_o.mul_start = 1'b1;
        state_d         = ST_INTEG_WAIT;
      end
      ST_INTEG_WAIT: begin
        cmd_o.mul_sel = MUL_INTEG;
        if (status_i.mul_done) begin
          cmd_o.mul_capture = 1'b1;
          state_d           = ST_DERIV;
        end
      end
      ST_DERIV: begin
        cmd_o.div_deriv = 1'b1;
        if (status_i.deriv_needed) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DERIV_WAIT;
        end else begin
          state_d = ST_P;
        end
      end
      ST_DERIV_WAIT: begin
        cmd_o.div_deriv = 1'b1;
        if (status_i.div_done) begin
          cmd_o.deriv_en = 1'b1;
          state_d        = ST_P;
        end
      end
      ST_P: begin
        cmd_o.mul_sel   = MUL_P;
        cmd_o.mul_start = 1'b1;
        state_d         = ST_P_WAIT;
      end
      ST_P_WAIT: begin
        cmd_o.mul_sel = MUL_P;
        if (status_i.mul_done) begin
          cmd_o.mul_capture = 1'b1;
          state_d           = ST_I;
        end
      end
      ST_I: begin
        cmd_o.mul_sel   = MUL_I;
        cmd_o.mul_start = 1'b1;
        state_d         = ST_I_WAIT;
      end
      ST_I_WAIT: begin
        cmd_o.mul_sel = MUL_I;
        if (status_i.mul_done) begin
          cmd_o.mul_capture = 1'b1;
          state_d           = ST_D;
        end
      end
      ST_D: begin
        cmd_o.mul_sel   = MUL_D;
        cmd_o.mul_start = 1'b1;
        state_d         = ST_D_WAIT;
      end
      ST_D_WAIT: begin
        cmd_o.mul_sel = MUL_D;
        if (status_i.mul_done) begin
          cmd_o.mul_capture = 1'b1;
          state_d           = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free_i) begin
          cmd_o.out_en = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

>>> src/pid_controller_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller step
// Fixed-point PID step with wrapped input, integral zone and output limits.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis carries one item per control step: target, measured
//   value and elapsed time. Master stream m_axis returns one drive item for
//   every accepted item, in order. The configuration channel writes gains,
//   limits, span, zone and mode by register index; write it only while idle.
//   One item at a time: a new item is accepted once the previous one has
//   reached the output register. Most of the work is the serial divider,
//   one bit per cycle: VALUE_WIDTH+1 steps for the input wrap and
//   VALUE_WIDTH+18 steps for the derivative; each is skipped when not needed.
//   The four products go through one chunked 16-bit multiplier.
//   A finished result sits in the output register; the next item is accepted
//   meanwhile and its result waits until the receiver takes the previous one.
//   Reset clears the integral, the previous error and the registers to their
//   defaults; the first item after reset has no derivative term.
// ----------------------------------------------------------------------------
module pid_controller_step
  import pcs_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Fields from bit 0: target, measured, step_time, zero padding.
  input  logic [((2*VALUE_WIDTH+DT_W+7)/8)*8-1:0] s_axis_tdata,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // Fields from bit 0: drive, zero padding.
  output logic [((VALUE_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]                    cfg_index_i,
  input  logic [VALUE_WIDTH-1:0]                  cfg_data_i
);

  localparam int OUT_W = ((VALUE_WIDTH + 7) / 8) * 8;

  logic [MODE_W-1:0]             mode_q;
  logic [VALUE_WIDTH-2:0]        span_q;
  logic [VALUE_WIDTH-2:0]        zone_q;
  logic signed [VALUE_WIDTH-1:0] min_q;
  logic signed [VALUE_WIDTH-1:0] max_q;
  logic signed [VALUE_WIDTH-1:0] kp_q;
  logic signed [VALUE_WIDTH-1:0] ki_q;
  logic signed [VALUE_WIDTH-1:0] kd_q;

  logic                          out_valid_q;
  logic                          out_free;
  logic signed [VALUE_WIDTH-1:0] drive;
  cmd_t                          cmd;
  status_t                       status;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      span_q <= '0;
      zone_q <= '1;
      min_q  <= {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      max_q  <= {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      kp_q   <= '0;
      ki_q   <= '0;
      kd_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MODE: mode_q <= cfg_data_i[MODE_W-1:0];
        CFG_SPAN: span_q <= cfg_data_i[VALUE_WIDTH-2:0];
        CFG_ZONE: zone_q <= cfg_data_i[VALUE_WIDTH-2:0];
        CFG_MIN:  min_q  <= cfg_data_i;
        CFG_MAX:  max_q  <= cfg_data_i;
        CFG_KP:   kp_q   <= cfg_data_i;
        CFG_KI:   ki_q   <= cfg_data_i;
        CFG_KD:   kd_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Output register handshake.
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_en) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  pcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pcs_datapath #(
    .FRAC_BITS   (FRAC_BITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .target_i    (s_axis_tdata[VALUE_WIDTH-1:0]),
    .measured_i  (s_axis_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]),
    .step_time_i (s_axis_tdata[2*VALUE_WIDTH+DT_W-1:2*VALUE_WIDTH]),
    .mode_i      (mode_q),
    .span_i      (span_q),
    .zone_i      (zone_q),
    .out_min_i   (min_q),
    .out_max_i   (max_q),
    .kp_i        (kp_q),
    .ki_i        (ki_q),
    .kd_i        (kd_q),
    .drive_o     (drive)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(unsigned'(drive));

  // Checks on the sequencing.
`include "pid_controller_step_assert.svh"

  `PCS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "item accepted while a step is running")
  `PCS_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, cmd.out_en, !out_valid_q || m_axis_tready, "waiting result overwritten")
  `PCS_ASSERT_IMPL(a_result_source, clk_i, rst_ni, $rose(out_valid_q), $past(cmd.out_en), "result appeared without a finished step")

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller step testbench
// Drives control steps and register writes into the controller, predicts each
// drive value with an independent fixed-point model and checks every result.
// ----------------------------------------------------------------------------
module tb;
  import pcs_pkg::*;

  localparam int VW = 32;
  localparam int IW = 80;
  localparam int OW = 32;
  localparam longint TERM_MAX = 64'sd2305843009213693951;
  localparam longint DRAIN_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [15:0] step_time;
    logic signed [31:0] measured;
    logic signed [31:0] target;
  } step_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic [IW-1:0] s_axis_tdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [OW-1:0] m_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [VW-1:0] cfg_data_i = '0;

  pid_controller_step uut (.*);

  // Model state and register copy.
  logic [1:0] mdl_mode;
  longint mdl_span, mdl_zone, mdl_min, mdl_max, mdl_kp, mdl_ki, mdl_kd;
  longint mdl_integ, mdl_prev_err;
  bit mdl_prev_valid;

  step_item_t pending_steps[$];
  logic [31:0] expected_drive[$];
  int errors = 0;
  longint cycle_count = 0;
  bit hold_off = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;

  initial forever #2 clk_i = ~clk_i;

  // Global cycle limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic longint mag_of(longint v);
    return v < 0 ? -v : v;
  endfunction

  // floor(a*b / 2^16), clamped to the term limit.
  function automatic longint scaled_product(longint a, longint b);
    logic signed [127:0] prod;
    logic signed [127:0] q;
    prod = 128'(signed'(a)) * 128'(signed'(b));
    q = prod >>> 16;
    if (q > 128'(TERM_MAX)) return TERM_MAX;
    if (q < -128'(TERM_MAX)) return -TERM_MAX;
    return longint'(q);
  endfunction

  function automatic longint clamp_integ(longint v);
    longint hi;
    hi = (64'sd1 <<< 39) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic void apply_reg(cfg_idx_e idx, logic [31:0] val);
    case (idx)
      CFG_MODE: mdl_mode = val[1:0];
      CFG_SPAN: mdl_span = longint'({1'b0, val[30:0]});
      CFG_ZONE: mdl_zone = longint'({1'b0, val[30:0]});
      CFG_MIN:  mdl_min = longint'(signed'(val));
      CFG_MAX:  mdl_max = longint'(signed'(val));
      CFG_KP:   mdl_kp = longint'(signed'(val));
      CFG_KI:   mdl_ki = longint'(signed'(val));
      CFG_KD:   mdl_kd = longint'(signed'(val));
      default: ;
    endcase
  endfunction

  // Advance the controller model by one step and return the drive value.
  function automatic logic [31:0] predict_drive(step_item_t it);
    longint err, dt, deriv, diff, q, r, integ, sum;
    err = longint'(it.target) - longint'(it.measured);
    dt = longint'({1'b0, it.step_time});
    deriv = 0;
    if (mdl_mode[MODE_WRAP] && mdl_span != 0) begin
      err = err % mdl_span;
      if (2 * mag_of(err) > mdl_span) err = err > 0 ? err - mdl_span : err + mdl_span;
    end
    if (mdl_mode[MODE_CLEAR] && err != 0 && mdl_integ != 0 && ((err < 0) != (mdl_integ < 0)))
      mdl_integ = 0;
    integ = 0;
    if (2 * mag_of(err) < mdl_zone) integ = clamp_integ(mdl_integ + scaled_product(err, dt));
    mdl_integ = integ;
    if (mdl_prev_valid && dt != 0) begin
      diff = err - mdl_prev_err;
      q = diff / dt;
      r = diff % dt;
      if (mag_of(q) > TERM_MAX / 65536) deriv = q < 0 ? -TERM_MAX : TERM_MAX;
      else deriv = q * 65536 + (r * 65536) / dt;
    end
    mdl_prev_err = err;
    mdl_prev_valid = 1'b1;
    sum = scaled_product(mdl_kp, err) + scaled_product(mdl_ki, integ)
        + scaled_product(mdl_kd, deriv);
    if (sum > mdl_max) sum = mdl_max;
    if (sum < mdl_min) sum = mdl_min;
    return sum[31:0];
  endfunction

  // Step driver: random gap before each item, valid held until accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_drive.push_back(predict_drive(step_item_t'(s_axis_tdata)));
        send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
        if (pending_steps.size() != 0 && send_gap == 0 && $urandom_range(0, 1)) begin
          s_axis_tdata <= pending_steps.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end else if (!s_axis_tvalid && pending_steps.size() != 0) begin
        if (send_gap > 0) send_gap <= send_gap - 1;
        else begin
          s_axis_tdata <= pending_steps.pop_front();
          s_axis_tvalid <= 1'b1;
        end
      end
    end
  end

  // Result monitor with random stalls and an optional long hold-off.
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_drive.size() == 0) begin
          $error("unexpected drive result %h", m_axis_tdata);
          errors++;
        end else begin
          want = expected_drive.pop_front();
          if (m_axis_tdata[31:0] !== want) begin
            $error("drive mismatch: expected %h actual %h", want, m_axis_tdata[31:0]);
            errors++;
          end
        end
        recv_gap <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 10);
        m_axis_tready <= 1'b0;
      end else if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic wait_idle();
    while (pending_steps.size() != 0 || s_axis_tvalid || expected_drive.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      3: return $urandom_range(0, 65535);
      default: return $urandom();
    endcase
  endfunction

  function automatic step_item_t rand_step(int near);
    step_item_t it;
    it.target = rand_word();
    it.measured = near ? it.target + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19))
                       : rand_word();
    case ($urandom_range(0, 4))
      0: it.step_time = 16'h0000;
      1: it.step_time = 16'hffff;
      default: it.step_time = $urandom();
    endcase
    return it;
  endfunction

  function automatic void queue_step(logic [31:0] t, logic [31:0] m, logic [15:0] dt);
    step_item_t it;
    it.target = t;
    it.measured = m;
    it.step_time = dt;
    pending_steps.push_back(it);
  endfunction

  task automatic random_config(int phase);
    write_reg(CFG_MODE, 2'(phase));
    write_reg(CFG_SPAN, phase == 7 ? 32'h7fffffff : ($urandom_range(0, 3) == 0 ? 32'd0
                                                   : $urandom_range(1, 32'h00ffffff)));
    write_reg(CFG_ZONE, phase == 6 ? 32'd0 : ($urandom_range(0, 1) ? 32'h7fffffff
                                             : $urandom_range(0, 32'h003fffff)));
    write_reg(CFG_MIN, phase == 5 ? 32'h00100000 : rand_word());
    write_reg(CFG_MAX, phase == 5 ? 32'hfff00000 : rand_word());
    write_reg(CFG_KP, rand_word());
    write_reg(CFG_KI, $urandom_range(0, 1) ? rand_word() : $urandom_range(0, 1 << 17));
    write_reg(CFG_KD, $urandom_range(0, 1) ? rand_word() : $urandom_range(0, 1 << 12));
  endtask

  // Stimulus: directed steps, then random phases with changing settings.
  initial begin
    mdl_mode = '0; mdl_span = 0; mdl_zone = 64'sd2147483647;
    mdl_min = -64'sd2147483648; mdl_max = 64'sd2147483647;
    mdl_kp = 0; mdl_ki = 0; mdl_kd = 0;
    mdl_integ = 0; mdl_prev_err = 0; mdl_prev_valid = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unity proportional gain, then field extremes, wrap and sign clear.
    write_reg(CFG_KP, 32'h00010000);
    write_reg(CFG_KI, 32'h00008000);
    write_reg(CFG_KD, 32'h00000100);
    queue_step(32'h00010000, 32'h00000000, 16'h0000);
    queue_step(32'h7fffffff, 32'h80000000, 16'hffff);
    queue_step(32'h80000000, 32'h7fffffff, 16'hffff);
    queue_step(32'h00000000, 32'h00000000, 16'h0001);
    queue_step(32'h00020000, 32'h00010000, 16'h0000);
    queue_step(32'hffffffff, 32'h00000000, 16'h8000);
    wait_idle();
    write_reg(CFG_MODE, 2'b11);
    write_reg(CFG_SPAN, 32'h00040000);
    write_reg(CFG_ZONE, 32'h00100000);
    queue_step(32'h00030000, 32'h00000000, 16'h4000);
    queue_step(32'h00020000, 32'h00000000, 16'h4000);
    queue_step(32'hfffe0000, 32'h00000000, 16'h4000);
    queue_step(32'h000a0000, 32'h00010000, 16'h4000);
    queue_step(32'hfff00000, 32'h00000000, 16'hffff);
    queue_step(32'h00001000, 32'h00000000, 16'h1000);
    queue_step(32'hffffe000, 32'h00000000, 16'h1000);
    wait_idle();
    write_reg(CFG_SPAN, 32'd0);
    write_reg(CFG_MIN, 32'h00050000);
    write_reg(CFG_MAX, 32'hfffb0000);
    queue_step(32'h00100000, 32'h00000000, 16'h1000);
    queue_step(32'h00000000, 32'h00100000, 16'h1000);
    wait_idle();

    for (int phase = 0; phase < 12; phase++) begin
      random_config(phase);
      for (int n = 0; n < 160; n++) pending_steps.push_back(rand_step($urandom_range(0, 2) != 0));
      if (phase == 2) begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      wait_idle();
    end

    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

>>> sim.f
+incdir+src
src/pcs_pkg.sv
src/pcs_div.sv
src/pcs_mul.sv
src/pcs_datapath.sv
src/pcs_ctrl.sv
src/pid_controller_step.sv
dv/tb.sv
